// ===== hdl/wmcs_pkg.sv =====
`timescale 1ns / 1ps

package wmcs_pkg;

    // Default depth of the sample store.
    localparam int DEF_MAX_SAMPLES = 1024;

    // Stream payload widths; the data widths are padded to whole bytes.
    localparam int IN_DATA_W  = 80;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 176;
    localparam int OUT_USER_W = 3;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    // Register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_GROUP_ID    = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CHECK_GROUP = 1'd1;

    // Request kinds.
    localparam logic REQ_PUSH   = 1'b0;
    localparam logic REQ_REPORT = 1'b1;

    // Result status codes.
    localparam logic [2:0] STAT_ACCEPTED  = 3'd0;
    localparam logic [2:0] STAT_MISMATCH  = 3'd1;
    localparam logic [2:0] STAT_FULL      = 3'd2;
    localparam logic [2:0] STAT_ZERO_SIG  = 3'd3;
    localparam logic [2:0] STAT_REPORT_OK = 3'd4;
    localparam logic [2:0] STAT_TOO_FEW   = 3'd5;

    // Request to the shared divider: (num_hi:num_lo) / den.
    typedef struct packed {
        logic        start;
        logic [63:0] num_hi;
        logic [63:0] num_lo;
        logic [63:0] den;
    } div_req_t;

    // Status back from the divider.
    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } div_rsp_t;

endpackage

// ===== hdl/wmcs_div.sv =====
`timescale 1ns / 1ps

// Restoring divider of a 128-bit dividend by a 64-bit divisor, one quotient
// bit per cycle. A zero divisor or a quotient that does not fit in 64 bits
// gives all ones.
module wmcs_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  wmcs_pkg::div_req_t req,
    output wmcs_pkg::div_rsp_t rsp
);
    import wmcs_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] lo_reg, lo_next;
    logic [63:0] q_reg, q_next;
    logic [63:0] den_reg, den_next;
    logic [64:0] shifted;
    logic        take;

    always_comb begin
        shifted = {rem_reg, lo_reg[63]};
        take    = shifted[64] || (shifted[63:0] >= den_reg);
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        if (req.start) begin
            den_next = req.den;
            if (req.den == 64'd0 || req.num_hi >= req.den) begin
                q_next    = '1;
                done_next = 1'b1;
            end else begin
                rem_next  = req.num_hi;
                lo_next   = req.num_lo;
                q_next    = '0;
                cnt_next  = 6'd63;
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            rem_next = take ? (shifted[63:0] - den_reg) : shifted[63:0];
            lo_next  = {lo_reg[62:0], 1'b0};
            q_next   = {q_reg[62:0], take};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;

endmodule

// ===== hdl/weighted_mean_chi_square.sv =====
`timescale 1ns / 1ps

// Inverse-variance weighted mean with chi-square, Q16.16 fixed point.
// Requests enter on the s_ stream: tuser selects push (0) or report (1),
// tdata carries the sample. Each request gives exactly one result on the
// m_ stream, with its status code in tuser and the statistics in tdata.
// Group number and group checking are set on the cfg_ port; the user
// must set them only while idle, which the block does not enforce. One
// request is worked on at a time. An accepted push does one 32x32
// multiply and two divisions on the shared bit-serial divider. A report
// does two divisions and a 32-step square root (both skipped when the
// weight sum is zero), then per stored sample one store read, the
// multiplies and one division, and, for two samples or more, one final
// division for the reduced chi-square. Samples live in one synchronous
// RAM of MAX_SAMPLES entries; no clearing pass is needed, since only
// entries below the sample count are ever read. Reset empties the store,
// clears the sums and sets group 0 with checking on. The result register
// frees s_tready as soon as it is loaded, so a stalled receiver holds
// only the end of the next request, not its acceptance.
module weighted_mean_chi_square #(
    parameter int MAX_SAMPLES = wmcs_pkg::DEF_MAX_SAMPLES
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // req_type
    input  logic [wmcs_pkg::IN_USER_W-1:0]   s_tuser,
    // sample_value [31:0], sample_sigma [63:32], group_tag [79:64]
    input  logic [wmcs_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // status
    output logic [wmcs_pkg::OUT_USER_W-1:0]  m_tuser,
    // mean [31:0], mean_sigma [63:32], chi_square [111:64],
    // degrees_free [121:112], reduced_chi [169:122], zero above
    output logic [wmcs_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_wr_en,
    input  logic [wmcs_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [wmcs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import wmcs_pkg::*;

    localparam int AddrW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CntW  = $clog2(MAX_SAMPLES + 1);
    localparam int DofW  = (CntW > 10) ? CntW : 10;
    localparam logic [CntW-1:0] MaxCount = CntW'(MAX_SAMPLES);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SQ    = 4'd1;
    localparam logic [3:0] ST_DIVW  = 4'd2;
    localparam logic [3:0] ST_DIVQ  = 4'd3;
    localparam logic [3:0] ST_ACC   = 4'd4;
    localparam logic [3:0] ST_DIVM  = 4'd5;
    localparam logic [3:0] ST_DIVS  = 4'd6;
    localparam logic [3:0] ST_SQRT  = 4'd7;
    localparam logic [3:0] ST_CHRD  = 4'd8;
    localparam logic [3:0] ST_CHMUL = 4'd9;
    localparam logic [3:0] ST_CHDIV = 4'd10;
    localparam logic [3:0] ST_RED   = 4'd11;
    localparam logic [3:0] ST_OUT   = 4'd12;

    localparam logic [63:0] ONE_Q48 = 64'h0001_0000_0000_0000;
    localparam logic [47:0] MASK48  = '1;

    // Configuration registers.
    logic [15:0] group_id_reg;
    logic        check_group_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_id_reg    <= '0;
            check_group_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_GROUP_ID:    group_id_reg    <= cfg_wdata;
                REG_CHECK_GROUP: check_group_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Control and datapath registers.
    logic [3:0]      state_reg, state_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [CntW-1:0] idx_reg, idx_next;
    logic [63:0]     sum_w_reg, sum_w_next;
    logic [63:0]     sum_vw_reg, sum_vw_next;
    logic [31:0]     v_reg, v_next;
    logic [31:0]     s_reg, s_next;
    logic [63:0]     s2_reg, s2_next;
    logic [63:0]     sq_reg, sq_next;
    logic [63:0]     w_reg, w_next;
    logic [63:0]     x_reg, x_next;
    logic [63:0]     r_reg, r_next;
    logic [63:0]     bit_reg, bit_next;
    logic [2:0]      status_reg, status_next;
    logic [31:0]     mean_reg, mean_next;
    logic [31:0]     msig_reg, msig_next;
    logic [47:0]     chi_reg, chi_next;
    logic [9:0]      dof_reg, dof_next;
    logic [47:0]     red_reg, red_next;
    logic            start_reg, start_next;
    logic            m_valid_reg, m_valid_next;
    logic [OUT_USER_W-1:0] m_user_reg, m_user_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    // Sample store: {sigma, value} per entry.
    logic [63:0]      mem [MAX_SAMPLES];
    logic [63:0]      rd_data_reg;
    logic             mem_we;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[count_reg[AddrW-1:0]] <= {s_reg, v_reg};
        end
        rd_data_reg <= mem[idx_reg[AddrW-1:0]];
    end

    div_req_t div_req;
    div_rsp_t div_rsp;

    wmcs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Helper values.
    logic [31:0]     v_mag;
    logic [63:0]     sw_mag;
    logic [CntW-1:0] dof_full;
    logic [DofW-1:0] dof_ext;
    logic [32:0]     diff;
    logic [31:0]     diff_mag;
    logic [64:0]     w_sum;
    logic [63:0]     term;
    logic [63:0]     vw_sum;
    logic [47:0]     chi_term;
    logic [48:0]     chi_sum;
    logic [63:0]     root_try;
    logic            accept;

    always_comb begin
        v_mag    = v_reg[31] ? (32'd0 - v_reg) : v_reg;
        sw_mag   = sum_vw_reg[63] ? (64'd0 - sum_vw_reg) : sum_vw_reg;
        dof_full = count_reg - CntW'(1);
        dof_ext  = DofW'(dof_full);
        diff     = {rd_data_reg[31], rd_data_reg[31:0]} - {mean_reg[31], mean_reg};
        diff_mag = diff[32] ? 32'(33'd0 - diff) : diff[31:0];
        w_sum    = {1'b0, sum_w_reg} + {1'b0, w_reg};
        term     = v_reg[31] ? (64'd0 - div_rsp.quot) : div_rsp.quot;
        vw_sum   = sum_vw_reg + term;
        chi_term = (div_rsp.quot[63:48] != 16'd0) ? MASK48 : div_rsp.quot[47:0];
        chi_sum  = {1'b0, chi_reg} + {1'b0, chi_term};
        root_try = r_reg + bit_reg;
        accept   = s_tvalid && s_tready;
    end

    // Operands for the divider follow the state.
    always_comb begin
        div_req.start  = start_reg;
        div_req.num_hi = '0;
        div_req.num_lo = '0;
        div_req.den    = '0;
        case (state_reg)
            ST_DIVW: begin
                div_req.num_lo = ONE_Q48;
                div_req.den    = s2_reg;
            end
            ST_DIVQ: begin
                div_req.num_lo = {v_mag, 32'd0};
                div_req.den    = s2_reg;
            end
            ST_DIVM: begin
                div_req.num_hi = {48'd0, sw_mag[63:48]};
                div_req.num_lo = {sw_mag[47:0], 16'd0};
                div_req.den    = sum_w_reg;
            end
            ST_DIVS: begin
                div_req.num_lo = ONE_Q48;
                div_req.den    = sum_w_reg;
            end
            ST_CHDIV: begin
                div_req.num_hi = {48'd0, sq_reg[63:48]};
                div_req.num_lo = {sq_reg[47:0], 16'd0};
                div_req.den    = s2_reg;
            end
            ST_RED: begin
                div_req.num_lo = {16'd0, chi_reg};
                div_req.den    = 64'(dof_full);
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        sum_w_next   = sum_w_reg;
        sum_vw_next  = sum_vw_reg;
        v_next       = v_reg;
        s_next       = s_reg;
        s2_next      = s2_reg;
        sq_next      = sq_reg;
        w_next       = w_reg;
        x_next       = x_reg;
        r_next       = r_reg;
        bit_next     = bit_reg;
        status_next  = status_reg;
        mean_next    = mean_reg;
        msig_next    = msig_reg;
        chi_next     = chi_reg;
        dof_next     = dof_reg;
        red_next     = red_reg;
        start_next   = 1'b0;
        m_valid_next = m_valid_reg;
        m_user_next  = m_user_reg;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    v_next    = s_tdata[31:0];
                    s_next    = s_tdata[63:32];
                    mean_next = '0;
                    msig_next = '0;
                    chi_next  = '0;
                    dof_next  = '0;
                    red_next  = '0;
                    idx_next  = '0;
                    state_next = ST_OUT;
                    if (s_tuser[0] == REQ_PUSH) begin
                        if (check_group_reg && s_tdata[79:64] != group_id_reg) begin
                            status_next = STAT_MISMATCH;
                        end else if (s_tdata[63:32] == 32'd0) begin
                            status_next = STAT_ZERO_SIG;
                        end else if (count_reg >= MaxCount) begin
                            status_next = STAT_FULL;
                        end else begin
                            status_next = STAT_ACCEPTED;
                            state_next  = ST_SQ;
                        end
                    end else begin
                        status_next = STAT_TOO_FEW;
                        if (count_reg != '0) begin
                            if (count_reg >= CntW'(2)) begin
                                status_next = STAT_REPORT_OK;
                            end
                            if (dof_ext > DofW'(1023)) begin
                                dof_next = 10'd1023;
                            end else begin
                                dof_next = dof_ext[9:0];
                            end
                            if (sum_w_reg == 64'd0) begin
                                msig_next  = '1;
                                state_next = ST_CHRD;
                            end else begin
                                start_next = 1'b1;
                                state_next = ST_DIVM;
                            end
                        end
                    end
                end
            end
            ST_SQ: begin
                s2_next    = 64'(s_reg) * 64'(s_reg);
                start_next = 1'b1;
                state_next = ST_DIVW;
            end
            ST_DIVW: begin
                if (div_rsp.done) begin
                    w_next     = div_rsp.quot;
                    start_next = 1'b1;
                    state_next = ST_DIVQ;
                end
            end
            ST_DIVQ: begin
                if (div_rsp.done) begin
                    sum_w_next = w_sum[64] ? '1 : w_sum[63:0];
                    // Signed saturation when both addends share a sign
                    // that the sum has lost.
                    if (sum_vw_reg[63] == term[63] && vw_sum[63] != term[63]) begin
                        sum_vw_next = term[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                    end else begin
                        sum_vw_next = vw_sum;
                    end
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                mem_we     = 1'b1;
                count_next = count_reg + CntW'(1);
                state_next = ST_OUT;
            end
            ST_DIVM: begin
                if (div_rsp.done) begin
                    if (sum_vw_reg[63]) begin
                        mean_next = (div_rsp.quot >= 64'h8000_0000) ? 32'h8000_0000
                                                                    : 32'd0 - div_rsp.quot[31:0];
                    end else begin
                        mean_next = (div_rsp.quot > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF
                                                                   : div_rsp.quot[31:0];
                    end
                    start_next = 1'b1;
                    state_next = ST_DIVS;
                end
            end
            ST_DIVS: begin
                if (div_rsp.done) begin
                    x_next     = div_rsp.quot;
                    r_next     = '0;
                    bit_next   = 64'd1 << 62;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (x_reg >= root_try) begin
                    x_next = x_reg - root_try;
                    r_next = (r_reg >> 1) + bit_reg;
                end else begin
                    r_next = r_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0]) begin
                    msig_next  = r_next[31:0];
                    state_next = ST_CHRD;
                end
            end
            ST_CHRD: begin
                state_next = ST_CHMUL;
            end
            ST_CHMUL: begin
                sq_next    = 64'(diff_mag) * 64'(diff_mag);
                s2_next    = 64'(rd_data_reg[63:32]) * 64'(rd_data_reg[63:32]);
                start_next = 1'b1;
                state_next = ST_CHDIV;
            end
            ST_CHDIV: begin
                if (div_rsp.done) begin
                    chi_next = chi_sum[48] ? MASK48 : chi_sum[47:0];
                    idx_next = idx_reg + CntW'(1);
                    if (idx_reg + CntW'(1) == count_reg) begin
                        if (count_reg >= CntW'(2)) begin
                            start_next = 1'b1;
                            state_next = ST_RED;
                        end else begin
                            state_next = ST_OUT;
                        end
                    end else begin
                        state_next = ST_CHRD;
                    end
                end
            end
            ST_RED: begin
                if (div_rsp.done) begin
                    red_next   = div_rsp.quot[47:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_user_next  = status_reg;
                    m_data_next  = {6'd0, red_reg, dof_reg, chi_reg, msig_reg, mean_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            sum_w_reg   <= '0;
            sum_vw_reg  <= '0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            sum_w_reg   <= sum_w_next;
            sum_vw_reg  <= sum_vw_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg    <= idx_next;
        v_reg      <= v_next;
        s_reg      <= s_next;
        s2_reg     <= s2_next;
        sq_reg     <= sq_next;
        w_reg      <= w_next;
        x_reg      <= x_next;
        r_reg      <= r_next;
        bit_reg    <= bit_next;
        status_reg <= status_next;
        mean_reg   <= mean_next;
        msig_reg   <= msig_next;
        chi_reg    <= chi_next;
        dof_reg    <= dof_next;
        red_reg    <= red_next;
        m_user_reg <= m_user_next;
        m_data_reg <= m_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_user_reg;
    assign m_tdata  = m_data_reg;

    // The sample count never passes the store depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MaxCount)
        else $error("sample count beyond store depth");

    // Every accepted request leaves the idle state.
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg != ST_IDLE)
        else $error("request accepted without leaving idle");

    // A store write only happens on a free entry and bumps the count.
    a_write_count: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> count_reg < MaxCount ##1 count_reg == $past(count_reg) + CntW'(1))
        else $error("store write out of step with sample count");

endmodule
